FILE: rtl/tps_pkg.sv
package tps_pkg;

  localparam int unsigned CoordW       = 32;
  localparam int unsigned MatW         = 16;
  localparam int unsigned MeshW        = 8;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned Corners      = 3;
  localparam int unsigned SegPts       = 2;
  // lane: multiply, round add, one quotient bit per stage, final add
  localparam int unsigned LaneLat      = CoordW + 3;
  localparam int unsigned FifoDepthDef = 2;

  localparam logic [CfgIdxW-1:0] CfgSliceHeight  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgModelOffsetZ = 2'd1;

  // edge endpoints in test order: a-b, b-c, c-a
  localparam logic [1:0] EdgeP [Corners] = '{2'd0, 2'd1, 2'd2};
  localparam logic [1:0] EdgeQ [Corners] = '{2'd1, 2'd2, 2'd0};

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [CoordW+1:0] height_t;

  typedef struct packed {
    coord_t [Corners-1:0] vx;
    coord_t [Corners-1:0] vy;
    coord_t [Corners-1:0] vz;
    logic [MatW-1:0]      material;
    logic [MeshW-1:0]     mesh;
  } tps_tri_t;

  typedef struct packed {
    coord_t            lov;
    logic [CoordW-1:0] mag;
    logic              neg;
  } tps_coord_t;

  typedef struct packed {
    logic [CoordW-1:0] num;
    logic [CoordW-1:0] den;
    tps_coord_t        cx;
    tps_coord_t        cy;
  } tps_pt_t;

  typedef struct packed {
    coord_t           plane;
    logic [MatW-1:0]  material;
    logic [MeshW-1:0] mesh;
  } tps_side_t;

  typedef struct packed {
    tps_pt_t [SegPts-1:0] pt;
    tps_side_t            side;
  } tps_job_t;

  function automatic height_t tps_widen(coord_t v);
    return {{2{v[CoordW-1]}}, v};
  endfunction

  function automatic tps_coord_t tps_coord(coord_t lo, coord_t hi);
    logic signed [CoordW:0] d;
    tps_coord_t             r;
    d     = {hi[CoordW-1], hi} - {lo[CoordW-1], lo};
    r.lov = lo;
    r.neg = d[CoordW];
    r.mag = d[CoordW] ? CoordW'(-d) : d[CoordW-1:0];
    return r;
  endfunction

  // setup of one crossing edge: ends ordered by z, num/den of the lerp
  function automatic tps_pt_t tps_point(tps_tri_t t, logic [1:0] p, logic [1:0] q,
                                        height_t h);
    logic [1:0] lo;
    logic [1:0] hi;
    height_t    n;
    height_t    d;
    tps_pt_t    r;
    lo = p;
    hi = q;
    if (t.vz[p] > t.vz[q]) begin
      lo = q;
      hi = p;
    end
    n     = h - tps_widen(t.vz[lo]);
    d     = tps_widen(t.vz[hi]) - tps_widen(t.vz[lo]);
    r.num = n[CoordW-1:0];
    r.den = d[CoordW-1:0];
    r.cx  = tps_coord(t.vx[lo], t.vx[hi]);
    r.cy  = tps_coord(t.vy[lo], t.vy[hi]);
    return r;
  endfunction

endpackage

FILE: rtl/tps_in_if.sv
interface tps_in_if import tps_pkg::*;;
  logic             valid;
  logic             ready;
  coord_t           vertex_a_x;
  coord_t           vertex_a_y;
  coord_t           vertex_a_z;
  coord_t           vertex_b_x;
  coord_t           vertex_b_y;
  coord_t           vertex_b_z;
  coord_t           vertex_c_x;
  coord_t           vertex_c_y;
  coord_t           vertex_c_z;
  logic [MatW-1:0]  material;
  logic [MeshW-1:0] mesh_index;

  modport source (
    output valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
           vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, material, mesh_index,
    input  ready
  );
  modport sink (
    input  valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
           vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, material, mesh_index,
    output ready
  );
endinterface

FILE: rtl/tps_out_if.sv
interface tps_out_if import tps_pkg::*;;
  logic             valid;
  logic             ready;
  coord_t           start_x;
  coord_t           start_y;
  coord_t           end_x;
  coord_t           end_y;
  coord_t           segment_z;
  logic [MatW-1:0]  segment_material;
  logic [MeshW-1:0] segment_mesh;

  modport source (
    output valid, start_x, start_y, end_x, end_y, segment_z, segment_material,
           segment_mesh,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, end_x, end_y, segment_z, segment_material,
           segment_mesh,
    output ready
  );
endinterface

FILE: rtl/triangle_plane_slice.sv
// From an accepted triangle to its segment: input register, queue, multiply,
//   round add, 32 quotient stages, final add. Throughput: one triangle per cycle
//   unless out_o.ready holds the pipe; set by the 32-stage pipelined dividers,
//   one per output coordinate, which accept a new operand every enabled cycle.
// Reset (rst_ni, async low): both registers read 0, pipeline and queue empty.
module triangle_plane_slice import tps_pkg::*; #(
  parameter int unsigned FifoDepth = FifoDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CoordW-1:0]  cfg_data_i,
  tps_in_if.sink             in_i,
  tps_out_if.source          out_o
);

  // configuration: world plane height and model z translation
  coord_t   slice_q;
  coord_t   offset_q;

  // front to queue, queue to back
  logic     push;
  logic     full;
  logic     pop;
  logic     empty;
  tps_job_t job_in;
  tps_job_t job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_q  <= '0;
      offset_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSliceHeight:  slice_q  <= cfg_data_i;
        CfgModelOffsetZ: offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: registers the triangle, finds the two crossing edges and sets
  // up numerator, denominator and signed deltas for each lerp
  tps_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .plane_i (slice_q),
    .offset_i(offset_q),
    .in_i    (in_i),
    .push_o  (push),
    .job_o   (job_in),
    .full_i  (full)
  );

  // short queue so front and back stall independently
  tps_fifo #(
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (job_in),
    .full_o (full),
    .pop_i  (pop),
    .data_o (job_out),
    .empty_o(empty)
  );

  // back: four divider lanes (start x/y, end x/y) with the sideband
  // riding alongside; the last stage doubles as the output register
  tps_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .job_i  (job_out),
    .empty_i(empty),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

FILE: rtl/tps_front.sv
module tps_front import tps_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  coord_t   plane_i,
  input  coord_t   offset_i,
  tps_in_if.sink   in_i,
  output logic     push_o,
  output tps_job_t job_o,
  input  logic     full_i
);

  logic               valid_q;
  tps_tri_t           tri_q;
  height_t            h;
  logic [Corners-1:0] below;
  logic [Corners-1:0] above;
  logic [Corners-1:0] crosses;
  logic               two;
  logic [1:0]         first;
  logic [1:0]         second;
  logic               advance;

  always_comb begin
    h = tps_widen(plane_i) - tps_widen(offset_i);
    for (int j = 0; j < Corners; j++) begin
      below[j] = tps_widen(tri_q.vz[j]) < h;
      above[j] = tps_widen(tri_q.vz[j]) > h;
    end
    for (int e = 0; e < Corners; e++) begin
      crosses[e] = (below[EdgeP[e]] && above[EdgeQ[e]]) ||
                   (below[EdgeQ[e]] && above[EdgeP[e]]);
    end
    two = (crosses == 3'b011) || (crosses == 3'b101) || (crosses == 3'b110);
    if (crosses[0]) begin
      first  = 2'd0;
      second = crosses[1] ? 2'd1 : 2'd2;
    end else begin
      first  = 2'd1;
      second = 2'd2;
    end
    job_o.pt[0]         = tps_point(tri_q, EdgeP[first], EdgeQ[first], h);
    job_o.pt[1]         = tps_point(tri_q, EdgeP[second], EdgeQ[second], h);
    job_o.side.plane    = plane_i;
    job_o.side.material = tri_q.material;
    job_o.side.mesh     = tri_q.mesh;
  end

  // triangles with other than two crossings are dropped here
  assign advance    = !valid_q || !two || !full_i;
  assign push_o     = valid_q && two && !full_i;
  assign in_i.ready = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && advance) begin
      tri_q.vx       <= {in_i.vertex_c_x, in_i.vertex_b_x, in_i.vertex_a_x};
      tri_q.vy       <= {in_i.vertex_c_y, in_i.vertex_b_y, in_i.vertex_a_y};
      tri_q.vz       <= {in_i.vertex_c_z, in_i.vertex_b_z, in_i.vertex_a_z};
      tri_q.material <= in_i.material;
      tri_q.mesh     <= in_i.mesh_index;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> $countones(crosses) == 2)
    else $error("push without two crossings");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && two && full_i |=> valid_q && $stable(tri_q))
    else $error("held triangle lost");

endmodule

FILE: rtl/tps_fifo.sv
module tps_fifo import tps_pkg::*; #(
  parameter int unsigned Depth = FifoDepthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  tps_job_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output tps_job_t data_o,
  output logic     empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tps_job_t          mem_q [Depth];
  logic [PtrW-1:0]   wr_q;
  logic [PtrW-1:0]   rd_q;
  logic [CntW-1:0]   cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("push into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop_i && empty_o))
    else $error("pop from empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count off");

endmodule

FILE: rtl/tps_lane.sv
module tps_lane import tps_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  tps_coord_t        coord_i,
  input  logic [CoordW-1:0] num_i,
  input  logic [CoordW-1:0] den_i,
  output coord_t            res_o
);

  localparam int unsigned Steps = CoordW;

  logic [2*CoordW-1:0] prod_q;
  logic [2*CoordW-1:0] div_q;
  logic [CoordW-1:0]   den0_q, den1_q;
  tps_coord_t          c0_q, c1_q;
  logic [CoordW-1:0]   rem_q [Steps];
  logic [CoordW-1:0]   low_q [Steps];
  logic [CoordW-1:0]   quo_q [Steps];
  logic [CoordW-1:0]   dd_q  [Steps];
  tps_coord_t          cc_q  [Steps];
  logic [CoordW-1:0]   rem_d [Steps];
  logic [CoordW-1:0]   low_d [Steps];
  logic [CoordW-1:0]   quo_d [Steps];
  coord_t              res_q;

  // restoring division, one quotient bit per stage; the quotient never
  // exceeds the magnitude, so the top half always starts below den
  always_comb begin
    logic [CoordW-1:0] r;
    logic [CoordW-1:0] l;
    logic [CoordW-1:0] qq;
    logic [CoordW-1:0] d;
    logic [CoordW:0]   t;
    logic              ge;
    for (int k = 0; k < Steps; k++) begin
      if (k == 0) begin
        r  = div_q[2*CoordW-1:CoordW];
        l  = div_q[CoordW-1:0];
        qq = '0;
        d  = den1_q;
      end else begin
        r  = rem_q[k-1];
        l  = low_q[k-1];
        qq = quo_q[k-1];
        d  = dd_q[k-1];
      end
      t        = {r, l[CoordW-1]};
      ge       = t >= {1'b0, d};
      rem_d[k] = ge ? CoordW'(t - {1'b0, d}) : t[CoordW-1:0];
      low_d[k] = {l[CoordW-2:0], 1'b0};
      quo_d[k] = {qq[CoordW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= coord_i.mag * num_i;
      den0_q <= den_i;
      c0_q   <= coord_i;
      div_q  <= prod_q + {{(CoordW+1){1'b0}}, den0_q[CoordW-1:1]};
      den1_q <= den0_q;
      c1_q   <= c0_q;
      for (int k = 0; k < Steps; k++) begin
        rem_q[k] <= rem_d[k];
        low_q[k] <= low_d[k];
        quo_q[k] <= quo_d[k];
        dd_q[k]  <= (k == 0) ? den1_q : dd_q[k-1];
        cc_q[k]  <= (k == 0) ? c1_q : cc_q[k-1];
      end
      res_q <= cc_q[Steps-1].neg ? cc_q[Steps-1].lov - coord_t'(quo_q[Steps-1])
                                 : cc_q[Steps-1].lov + coord_t'(quo_q[Steps-1]);
    end
  end

  assign res_o = res_q;

endmodule

FILE: rtl/tps_back.sv
module tps_back import tps_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  tps_job_t job_i,
  input  logic     empty_i,
  output logic     pop_o,
  tps_out_if.source out_o
);

  logic            v_q    [LaneLat];
  tps_side_t       side_q [LaneLat];
  logic            en;
  coord_t          res [2*SegPts];

  // whole pipe moves unless the finished word is stuck at the output
  assign en    = !v_q[LaneLat-1] || out_o.ready;
  assign pop_o = en && !empty_i;

  for (genvar p = 0; p < SegPts; p++) begin : g_pt
    tps_lane u_lane_x (
      .clk_i  (clk_i),
      .en_i   (en),
      .coord_i(job_i.pt[p].cx),
      .num_i  (job_i.pt[p].num),
      .den_i  (job_i.pt[p].den),
      .res_o  (res[2*p])
    );
    tps_lane u_lane_y (
      .clk_i  (clk_i),
      .en_i   (en),
      .coord_i(job_i.pt[p].cy),
      .num_i  (job_i.pt[p].num),
      .den_i  (job_i.pt[p].den),
      .res_o  (res[2*p+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LaneLat; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (en) begin
      for (int k = 0; k < LaneLat; k++) begin
        v_q[k] <= (k == 0) ? !empty_i : v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < LaneLat; k++) begin
        side_q[k] <= (k == 0) ? job_i.side : side_q[k-1];
      end
    end
  end

  assign out_o.valid            = v_q[LaneLat-1];
  assign out_o.start_x          = res[0];
  assign out_o.start_y          = res[1];
  assign out_o.end_x            = res[2];
  assign out_o.end_y            = res[3];
  assign out_o.segment_z        = side_q[LaneLat-1].plane;
  assign out_o.segment_material = side_q[LaneLat-1].material;
  assign out_o.segment_mesh     = side_q[LaneLat-1].mesh;

endmodule
